[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is checked through reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/mh2_pkg.sv]
`default_nettype none

package mh2_pkg;

	// Hash constants.
	localparam logic [31:0] MIX_MULT    = 32'h5bd1e995;
	localparam int          MIX_SHIFT   = 24;
	localparam int          FIN_SHIFT_A = 13;
	localparam int          FIN_SHIFT_B = 15;

	// Command queue between the front and back ends.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// One command for the back end, built from one accepted request.
	typedef struct packed {
		logic        seed;     // load the accumulator with seed_len
		logic        word_en;  // mix a complete word held in data
		logic        tail_en;  // fold the leftover bytes held in data
		logic        last;     // finalise and deliver a hash
		logic [31:0] seed_len;
		logic [31:0] data;
	} cmd_t;

	// Queue status seen by both ends.
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// Back-end sequencer states.
	typedef enum logic [2:0] {
		B_IDLE,
		B_WK1,
		B_WK2,
		B_WK3,
		B_TAIL,
		B_FIN,
		B_EMIT
	} back_state_t;

endpackage

`default_nettype wire

[rtl/mh2_cmd_queue.sv]
`default_nettype none

module mh2_cmd_queue (
	input  wire                logic       clk,
	input  wire                logic       arst_n,
	input  wire                logic       push,
	input  wire                mh2_pkg::cmd_t wr_cmd,
	input  wire                logic       pop,
	output mh2_pkg::cmd_t      rd_cmd,
	output mh2_pkg::fifo_stat_t stat
);

	mh2_pkg::cmd_t                   slot_q [mh2_pkg::FIFO_DEPTH];
	logic [mh2_pkg::FIFO_AW-1:0]     wr_ptr_q;
	logic [mh2_pkg::FIFO_AW-1:0]     rd_ptr_q;
	logic [mh2_pkg::FIFO_AW:0]       count_q;

	localparam logic [mh2_pkg::FIFO_AW-1:0] LAST_PTR = mh2_pkg::FIFO_AW'(mh2_pkg::FIFO_DEPTH - 1);
	localparam logic [mh2_pkg::FIFO_AW:0]   FULL_CNT = (mh2_pkg::FIFO_AW + 1)'(mh2_pkg::FIFO_DEPTH);

	// Status and read port.
	assign stat.full  = (count_q == FULL_CNT);
	assign stat.empty = (count_q == '0);
	assign rd_cmd     = slot_q[rd_ptr_q];

	// Storage is written without reset; only pointers and count are cleared.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/mh2_front.sv]
`default_nettype none

module mh2_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [7:0]          data_byte,
	input  wire logic                byte_valid,
	input  wire logic                first,
	input  wire logic                last,
	input  wire logic [31:0]         msg_length,
	input  wire mh2_pkg::fifo_stat_t stat,
	output logic                     push,
	output mh2_pkg::cmd_t            cmd
);

	logic [23:0] buf_q;
	logic [1:0]  phase_q;
	logic [23:0] eff_buf;
	logic [1:0]  eff_phase;
	logic [23:0] buf_d;
	logic [1:0]  phase_d;
	logic        word_en;
	logic        accept;

	// A request is taken whenever the queue has room.
	assign in_ready = !stat.full;
	assign accept   = in_valid && in_ready;

	// Gather bytes little-endian and classify the request.
	always_comb begin
		eff_buf   = first ? '0 : buf_q;
		eff_phase = first ? '0 : phase_q;
		buf_d     = eff_buf;
		phase_d   = eff_phase;
		word_en   = 1'b0;
		if (byte_valid) begin
			case (eff_phase)
				2'd0: begin
					buf_d   = {eff_buf[23:8], data_byte};
					phase_d = 2'd1;
				end
				2'd1: begin
					buf_d   = {eff_buf[23:16], data_byte, eff_buf[7:0]};
					phase_d = 2'd2;
				end
				2'd2: begin
					buf_d   = {data_byte, eff_buf[15:0]};
					phase_d = 2'd3;
				end
				default: begin
					word_en = 1'b1;
					buf_d   = '0;
					phase_d = 2'd0;
				end
			endcase
		end

		cmd.seed     = first;
		cmd.word_en  = word_en;
		cmd.tail_en  = last && (phase_d != 2'd0);
		cmd.last     = last;
		cmd.seed_len = msg_length;
		cmd.data     = word_en ? {data_byte, eff_buf} : {8'd0, buf_d};

		// Requests that only add a byte to the buffer need no back-end work.
		push = accept && (first || word_en || last);
	end

	// Byte buffer, emptied once a message ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q   <= '0;
			phase_q <= '0;
		end else if (accept) begin
			buf_q   <= last ? '0 : buf_d;
			phase_q <= last ? '0 : phase_d;
		end
	end

endmodule

`default_nettype wire

[rtl/mh2_back.sv]
`default_nettype none

module mh2_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mh2_pkg::fifo_stat_t stat,
	input  wire mh2_pkg::cmd_t       cmd_in,
	output logic                     pop,
	output logic [31:0]              hash_value,
	output logic                     out_valid,
	input  wire logic                out_ready
);

	mh2_pkg::back_state_t state_q;
	mh2_pkg::back_state_t state_d;
	mh2_pkg::cmd_t        cmd_q;
	logic [31:0]          h_q;
	logic [31:0]          h_d;
	logic [31:0]          t_q;
	logic [31:0]          t_d;
	logic [31:0]          res_q;
	logic                 res_valid_q;
	logic                 res_load;
	logic [31:0]          mul_in;
	logic [31:0]          prod;

	// The one multiplier; every product in the hash is by the mix constant.
	assign prod = mul_in * mh2_pkg::MIX_MULT;

	// Sequencer: next state, multiplier operand and register updates.
	always_comb begin
		state_d  = state_q;
		h_d      = h_q;
		t_d      = t_q;
		mul_in   = '0;
		pop      = 1'b0;
		res_load = 1'b0;
		case (state_q)
			mh2_pkg::B_IDLE: begin
				if (!stat.empty) begin
					pop = 1'b1;
					if (cmd_in.seed) begin
						h_d = cmd_in.seed_len;
					end
					if (cmd_in.word_en) begin
						state_d = mh2_pkg::B_WK1;
					end else if (cmd_in.tail_en) begin
						state_d = mh2_pkg::B_TAIL;
					end else if (cmd_in.last) begin
						state_d = mh2_pkg::B_FIN;
					end
				end
			end
			mh2_pkg::B_WK1: begin
				mul_in  = cmd_q.data;
				t_d     = prod;
				state_d = mh2_pkg::B_WK2;
			end
			mh2_pkg::B_WK2: begin
				mul_in  = t_q ^ (t_q >> mh2_pkg::MIX_SHIFT);
				t_d     = prod;
				state_d = mh2_pkg::B_WK3;
			end
			mh2_pkg::B_WK3: begin
				mul_in  = h_q;
				h_d     = prod ^ t_q;
				state_d = cmd_q.last ? mh2_pkg::B_FIN : mh2_pkg::B_IDLE;
			end
			mh2_pkg::B_TAIL: begin
				mul_in  = h_q ^ cmd_q.data;
				h_d     = prod;
				state_d = mh2_pkg::B_FIN;
			end
			mh2_pkg::B_FIN: begin
				mul_in  = h_q ^ (h_q >> mh2_pkg::FIN_SHIFT_A);
				t_d     = prod;
				state_d = mh2_pkg::B_EMIT;
			end
			mh2_pkg::B_EMIT: begin
				if (!res_valid_q || out_ready) begin
					res_load = 1'b1;
					state_d  = mh2_pkg::B_IDLE;
				end
			end
			default: begin
				state_d = mh2_pkg::B_IDLE;
			end
		endcase
	end

	// State, accumulator and output flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mh2_pkg::B_IDLE;
			h_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			h_q     <= h_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (out_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Working registers and the output register.
	always_ff @(posedge clk) begin
		t_q <= t_d;
		if (pop) begin
			cmd_q <= cmd_in;
		end
		if (res_load) begin
			res_q <= t_q ^ (t_q >> mh2_pkg::FIN_SHIFT_B);
		end
	end

	assign hash_value = res_q;
	assign out_valid  = res_valid_q;

endmodule

`default_nettype wire

[rtl/murmurhash2_byte_stream.sv]
// Accepts one byte request per cycle while the four-entry command queue has room.
// A complete word takes the back-end states B_WK1, B_WK2 and B_WK3 on the single 32x32
// multiplier, so a steady stream of bytes is sustained at one per cycle.
// After any final word or tail step, B_FIN and then B_EMIT register the hash.
// Reset clears the accumulator, the byte buffer, the queue and the output flag.
`default_nettype none

module murmurhash2_byte_stream (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        byte_valid,
	input  wire logic        first,
	input  wire logic        last,
	input  wire logic [31:0] msg_length,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      hash_value
);

	mh2_pkg::fifo_stat_t stat;
	mh2_pkg::cmd_t       wr_cmd;
	mh2_pkg::cmd_t       rd_cmd;
	logic                push;
	logic                pop;

	// Front end: byte gathering and classification.
	mh2_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.byte_valid (byte_valid),
		.first      (first),
		.last       (last),
		.msg_length (msg_length),
		.stat       (stat),
		.push       (push),
		.cmd        (wr_cmd)
	);

	// Command queue.
	mh2_cmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.rd_cmd (rd_cmd),
		.stat   (stat)
	);

	// Back end: word mixing, tail fold and finalisation.
	mh2_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.stat       (stat),
		.cmd_in     (rd_cmd),
		.pop        (pop),
		.hash_value (hash_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready)
	);

endmodule

`default_nettype wire

[rtl/mh2_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module mh2_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] hash_value
);

	// A stalled result holds its value.
	`ASSERT_CLK(a_out_hold, clk, arst_n,
		out_valid && !out_ready |=> out_valid && $stable(hash_value),
		"result changed while stalled")

	// The queue is empty straight after reset, so a request is taken.
	`ASSERT_ALWAYS(a_ready_after_reset, clk, $rose(arst_n) |-> in_ready,
		"not ready after reset")

	// No result can come out of the back end straight after reset.
	`ASSERT_ALWAYS(a_no_early_result, clk,
		$rose(arst_n) |-> !out_valid ##1 !out_valid ##1 !out_valid,
		"result too soon after reset")

	// A result only leaves when it has been taken.
	`ASSERT_CLK(a_out_drop, clk, arst_n, $fell(out_valid) |-> $past(out_ready),
		"result dropped")

endmodule

bind murmurhash2_byte_stream mh2_checker u_mh2_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.hash_value (hash_value)
);

`default_nettype wire
